// ===== design/scpr_pkg.sv =====
// Package for the second-chance page replacer: request/result structs and codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scpr_pkg;
  localparam int unsigned COST_W = 30;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
  localparam logic [5:0] FREED_MAX = 6'd63;

  typedef enum logic [1:0] {
    REG_HIT_COST    = 2'd0,
    REG_FAULT_COST  = 2'd1,
    REG_WFAULT_COST = 2'd2,
    REG_WB_COST     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic        kind;
    logic [3:0]  process;
    logic [14:0] address;
    logic        is_write;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  frame;
    logic        evicted;
    logic [3:0]  victim_process;
    logic [4:0]  victim_page;
    logic        victim_dirty;
    logic [5:0]  freed_count;
    logic [29:0] cost_ns;
  } res_t;

  typedef struct packed {
    logic [9:0]  hit_cost;
    logic [23:0] fault_cost;
    logic [23:0] write_fault_cost;
    logic [23:0] writeback_cost;
  } cfg_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [23:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {{(COST_W-23){1'b0}}, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== design/scpr_cfg_regs.sv =====
// Cost configuration registers of the page replacer.
// Depends on scpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scpr_cfg_regs import scpr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  output cfg_t             cfg_o
);
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_cost         <= 10'd10;
      cfg_q.fault_cost       <= 24'd14000000;
      cfg_q.write_fault_cost <= 24'd14000000;
      cfg_q.writeback_cost   <= 24'd14000000;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_HIT_COST:    cfg_q.hit_cost <= cfg_data_i[9:0];
        REG_FAULT_COST:  cfg_q.fault_cost <= cfg_data_i;
        REG_WFAULT_COST: cfg_q.write_fault_cost <= cfg_data_i;
        REG_WB_COST:     cfg_q.writeback_cost <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

// ===== design/scpr_engine.sv =====
// Table engine: page and frame memories with a read-modify-write sequencer.
// Depends on scpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scpr_engine import scpr_pkg::*; #(
  parameter int unsigned FRAMES = 256,
  parameter int unsigned PROCESSES = 16,
  parameter int unsigned PAGES_PER_PROCESS = 32,
  parameter int unsigned PAGE_BYTES = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  req_t      req_i,
  input  cfg_t      cfg_i,
  output logic      busy_o,
  output logic      done_o,
  output res_t      res_o
);
  localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int unsigned GW = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
  localparam int unsigned TS = PROCESSES * PAGES_PER_PROCESS;
  localparam int unsigned EW = (TS > 1) ? $clog2(TS) : 1;
  localparam int unsigned OW = $clog2(PAGE_BYTES);
  localparam int unsigned CW = FW + 1;
  localparam int unsigned TW = GW + 1;

  // Frame memory word: in_use, referenced, owner, page. Page word: valid, dirty, frame.
  typedef struct packed {
    logic          used;
    logic          ref_b;
    logic [PW-1:0] owner;
    logic [GW-1:0] page;
  } fword_t;
  typedef struct packed {
    logic          valid;
    logic          dirty;
    logic [FW-1:0] frame;
  } pword_t;

  fword_t fmem [FRAMES];
  pword_t pmem [TS];

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PLOOK, S_PDEC, S_SCAN, S_SCHK, S_HAND, S_HCHK,
    S_VRD, S_VWR, S_FILL, S_TRD, S_TCHK, S_DONE
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;
  logic [FW-1:0] hand_q, f_q;
  logic [PW-1:0] proc_q;
  logic [GW-1:0] page_q;
  logic          wr_q, kind_q;
  logic [TW-1:0] tp_q;
  logic [29:0]   cost_q;
  logic [5:0]    freed_q;
  res_t          res_q;
  logic          done_q;

  // Memory ports.
  logic          fre, fwe, pre, pwe;
  logic [FW-1:0] fra, fwa;
  logic [EW-1:0] pra, pwa;
  fword_t        frd, fwd;
  pword_t        prd, pwd;

  always_ff @(posedge clk_i) begin
    if (fwe) fmem[fwa] <= fwd;
    if (fre) frd <= fmem[fra];
    if (pwe) pmem[pwa] <= pwd;
    if (pre) prd <= pmem[pra];
  end

  logic [PW-1:0] proc_in;
  logic [GW-1:0] page_in;
  always_comb begin
    proc_in = PW'(req_i.process % PROCESSES);
    page_in = GW'((req_i.address >> OW) % PAGES_PER_PROCESS);
  end

  function automatic logic [EW-1:0] ent(input logic [PW-1:0] p, input logic [GW-1:0] g);
    return EW'(p * PAGES_PER_PROCESS + g);
  endfunction

  always_comb begin
    fre = 1'b0; fwe = 1'b0; pre = 1'b0; pwe = 1'b0;
    fra = '0; fwa = '0; pra = '0; pwa = '0; fwd = '0; pwd = '0;
    case (state_q)
      S_CLEAR: begin
        fwe = 1'b1; fwa = cnt_q[FW-1:0];
        pwe = (32'(cnt_q) < TS); pwa = EW'(cnt_q);
      end
      S_IDLE: begin
        pre = 1'b1; pra = ent(proc_in, page_in);
      end
      S_PDEC: begin
        if (prd.valid) begin
          fre = 1'b1; fra = prd.frame;
          pwe = 1'b1; pwa = ent(proc_q, page_q);
          pwd = '{valid: 1'b1, dirty: prd.dirty | wr_q, frame: prd.frame};
        end else begin
          fre = 1'b1; fra = '0;
        end
      end
      S_SCAN: begin
        // Hit path: write back the frame word with the reference bit set.
        if (res_q.hit) begin
          fwe = 1'b1; fwa = res_q.frame[FW-1:0]; fwd = frd; fwd.ref_b = 1'b1;
        end
      end
      S_SCHK: begin
        fre = 1'b1; fra = FW'(cnt_q + 1'b1);
      end
      S_HAND: begin
        fre = 1'b1; fra = hand_q;
      end
      S_HCHK: begin
        if (frd.ref_b) begin
          fwe = 1'b1; fwa = hand_q; fwd = frd; fwd.ref_b = 1'b0;
          fre = 1'b1; fra = FW'((32'(hand_q) + 1) % FRAMES);
        end else begin
          pre = 1'b1; pra = ent(frd.owner, frd.page);
        end
      end
      S_VWR: begin
        pwe = 1'b1; pwa = ent(res_q.victim_process[PW-1:0], res_q.victim_page[GW-1:0]);
        pwd = '0;
      end
      S_FILL: begin
        fwe = 1'b1; fwa = f_q;
        fwd = '{used: 1'b1, ref_b: 1'b1, owner: proc_q, page: page_q};
        pwe = 1'b1; pwa = ent(proc_q, page_q);
        pwd = '{valid: 1'b1, dirty: wr_q, frame: f_q};
      end
      S_TRD: begin
        pre = 1'b1; pra = ent(proc_q, tp_q[GW-1:0]);
      end
      S_TCHK: begin
        if (prd.valid) begin
          pwe = 1'b1; pwa = ent(proc_q, tp_q[GW-1:0]); pwd = '0;
          fwe = 1'b1; fwa = prd.frame; fwd = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; cnt_q <= '0; hand_q <= '0; done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (32'(cnt_q) + 1 >= ((TS > FRAMES) ? TS : FRAMES)) state_q <= S_IDLE;
        end
        S_IDLE: if (start_i) begin
          kind_q <= req_i.kind; proc_q <= proc_in; page_q <= page_in;
          wr_q <= req_i.is_write; res_q <= '0; cost_q <= '0; freed_q <= '0;
          tp_q <= '0;
          state_q <= req_i.kind ? S_TRD : S_PLOOK;
        end
        S_PLOOK: state_q <= S_PDEC;
        S_PDEC: begin
          if (prd.valid) begin
            res_q.hit <= 1'b1; res_q.frame <= 8'(prd.frame);
            res_q.cost_ns <= 30'(cfg_i.hit_cost);
            state_q <= S_SCAN; // reference bit update
            cnt_q <= '1;
          end else begin
            cnt_q <= '0; state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (res_q.hit) begin
            // frd holds the hit frame's word; set its reference bit.
            state_q <= S_DONE;
          end else state_q <= S_SCHK;
        end
        S_SCHK: begin
          if (!frd.used) begin
            f_q <= cnt_q[FW-1:0]; state_q <= S_FILL;
          end else if (32'(cnt_q) + 1 >= FRAMES) begin
            state_q <= S_HAND;
          end else cnt_q <= cnt_q + 1'b1;
        end
        S_HAND: state_q <= S_HCHK;
        S_HCHK: begin
          if (frd.ref_b) begin
            hand_q <= FW'((32'(hand_q) + 1) % FRAMES);
          end else begin
            res_q.evicted <= 1'b1;
            res_q.victim_process <= 4'(frd.owner);
            res_q.victim_page <= 5'(frd.page);
            f_q <= hand_q;
            hand_q <= FW'((32'(hand_q) + 1) % FRAMES);
            state_q <= S_VRD;
          end
        end
        S_VRD: state_q <= S_VWR;
        S_VWR: begin
          res_q.victim_dirty <= prd.dirty;
          if (prd.dirty) cost_q <= sat_add(cost_q, cfg_i.writeback_cost);
          state_q <= S_FILL;
        end
        S_FILL: begin
          res_q.frame <= 8'(f_q);
          cost_q <= wr_q ? sat_add(sat_add(cost_q, cfg_i.fault_cost), cfg_i.write_fault_cost)
                         : sat_add(cost_q, cfg_i.fault_cost);
          state_q <= S_DONE;
        end
        S_TRD: state_q <= S_TCHK;
        S_TCHK: begin
          if (prd.valid) begin
            if (freed_q != FREED_MAX) freed_q <= freed_q + 1'b1;
            if (prd.dirty) cost_q <= sat_add(cost_q, cfg_i.writeback_cost);
          end
          tp_q <= tp_q + 1'b1;
          state_q <= (32'(tp_q) + 1 >= PAGES_PER_PROCESS) ? S_DONE : S_TRD;
        end
        S_DONE: begin
          done_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res_o = res_q;
    if (kind_q) begin
      res_o = '0; res_o.freed_count = freed_q; res_o.cost_ns = cost_q;
    end else if (!res_q.hit) begin
      res_o.cost_ns = cost_q;
    end
  end
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
endmodule
`default_nettype wire

// ===== design/second_chance_page_replacer_top.sv =====
// Top level of the second-chance page replacer.
// Depends on scpr_pkg, scpr_cfg_regs and scpr_engine.
`timescale 1ns / 1ps
`default_nettype none
// Usage: a request (access or terminate) is presented on req_i with start
// high; it is taken at a clock edge where busy is low. Exactly one result
// appears on res_o for one cycle, marked by done_o; the receiver cannot stall,
// so it must take the result in that cycle.
// A hit does a page table read, then a reference bit update.
// A fault scans the frame memory one entry a cycle for the lowest free frame,
// over at most FRAMES entries, then the clock hand steps one frame per cycle,
// up to FRAMES+1 steps, plus a victim page read and write. A terminate walks
// the process's PAGES_PER_PROCESS entries, a read and a check state for each.
// The registered reads of the frame and page memories set this sequencing;
// one request is in flight at a time.
// Reset: after rst_ni releases, a clearing pass writes every frame and page
// entry, with busy high.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once;
// the user must make them only while the block is idle; it is not enforced.
module second_chance_page_replacer_top import scpr_pkg::*; #(
  parameter int unsigned FRAMES = 256,
  parameter int unsigned PROCESSES = 16,
  parameter int unsigned PAGES_PER_PROCESS = 32,
  parameter int unsigned PAGE_BYTES = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output res_t             res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i
);
  cfg_t cfg;

  scpr_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  scpr_engine #(
    .FRAMES(FRAMES), .PROCESSES(PROCESSES),
    .PAGES_PER_PROCESS(PAGES_PER_PROCESS), .PAGE_BYTES(PAGE_BYTES)
  ) u_eng (
    .clk_i, .rst_ni, .start_i(start), .req_i, .cfg_i(cfg),
    .busy_o(busy), .done_o, .res_o
  );
endmodule
`default_nettype wire

// ===== design/scpr_checker.sv =====
// Port-level checks of the page replacer, bound to the top level.
// Depends on scpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scpr_checker import scpr_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input res_t      res_o
);
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accept");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe lasted two cycles");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.hit) |-> (!res_o.evicted && res_o.freed_count == 6'd0))
    else $error("hit with eviction or freed frames");
endmodule
bind second_chance_page_replacer_top scpr_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .res_o
);
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for second_chance_page_replacer_top.
// Depends on scpr_pkg and the block's RTL; holds its own page/frame table predictor.
`timescale 1ns / 1ps
module tb;
  import scpr_pkg::*;

  localparam int unsigned NFRAMES = 256;
  localparam int unsigned NPAGES  = 32;
  localparam int unsigned NSLOTS  = 16;
  localparam int unsigned RANDOM_REQUESTS = 1200;
  localparam int unsigned SETTLE_CYCLES = 1200;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        done_o;
  res_t        res_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;

  second_chance_page_replacer_top i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .done_o    (done_o),
    .res_o     (res_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // The clock runs at 8 ns. Inputs move on the falling edge so that every
  // rising edge sees stable values.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Predictor state: a private copy of the frame table, the page tables,
  // the clock hand and the cost registers.
  cfg_t        cost_regs;
  logic        fr_used  [NFRAMES];
  logic        fr_ref   [NFRAMES];
  logic [3:0]  fr_owner [NFRAMES];
  logic [4:0]  fr_page  [NFRAMES];
  logic        pg_valid [NSLOTS*NPAGES];
  logic        pg_dirty [NSLOTS*NPAGES];
  logic [7:0]  pg_frame [NSLOTS*NPAGES];
  logic [7:0]  hand;

  res_t        expected_results[$];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned faults_seen;
  int unsigned evictions_seen;
  int unsigned terminates_seen;

  function automatic logic [29:0] add_cost(logic [29:0] a, logic [23:0] b);
    logic [30:0] s;
    s = {1'b0, a} + 31'(b);
    return s[30] ? COST_MAX : s[29:0];
  endfunction

  task automatic reset_tables();
    cost_regs = '{hit_cost: 10'd10, fault_cost: 24'd14000000,
                  write_fault_cost: 24'd14000000, writeback_cost: 24'd14000000};
    for (int i = 0; i < NFRAMES; i++) begin
      fr_used[i] = 1'b0;
      fr_ref[i] = 1'b0;
      fr_owner[i] = '0;
      fr_page[i] = '0;
    end
    for (int i = 0; i < NSLOTS*NPAGES; i++) begin
      pg_valid[i] = 1'b0;
      pg_dirty[i] = 1'b0;
      pg_frame[i] = '0;
    end
    hand = '0;
  endtask

  // Works out the result of one request and updates the tables.
  function automatic res_t translate(req_t rq);
    res_t r;
    int unsigned e, f, ve, freed;
    logic found;
    r = '0;
    if (rq.kind) begin
      freed = 0;
      for (int p = 0; p < NPAGES; p++) begin
        e = rq.process * NPAGES + p;
        if (pg_valid[e]) begin
          if (pg_dirty[e]) r.cost_ns = add_cost(r.cost_ns, cost_regs.writeback_cost);
          fr_used[pg_frame[e]] = 1'b0;
          fr_ref[pg_frame[e]] = 1'b0;
          pg_valid[e] = 1'b0;
          pg_dirty[e] = 1'b0;
          freed++;
        end
      end
      r.freed_count = (freed > 63) ? FREED_MAX : 6'(freed);
    end else begin
      e = rq.process * NPAGES + rq.address[14:10];
      if (pg_valid[e]) begin
        r.hit = 1'b1;
        r.frame = pg_frame[e];
        fr_ref[pg_frame[e]] = 1'b1;
        if (rq.is_write) pg_dirty[e] = 1'b1;
        r.cost_ns = 30'(cost_regs.hit_cost);
      end else begin
        found = 1'b0;
        f = 0;
        for (int i = 0; i < NFRAMES; i++) begin
          if (!found && !fr_used[i]) begin
            found = 1'b1;
            f = i;
          end
        end
        // With every frame busy, the hand clears reference bits until it
        // lands on an unreferenced frame; that page is the victim.
        while (!found) begin
          if (fr_ref[hand]) begin
            fr_ref[hand] = 1'b0;
            hand = hand + 8'd1;
          end else begin
            ve = fr_owner[hand] * NPAGES + fr_page[hand];
            r.evicted = 1'b1;
            r.victim_process = fr_owner[hand];
            r.victim_page = fr_page[hand];
            r.victim_dirty = pg_dirty[ve];
            pg_valid[ve] = 1'b0;
            pg_dirty[ve] = 1'b0;
            if (r.victim_dirty) r.cost_ns = add_cost(r.cost_ns, cost_regs.writeback_cost);
            f = hand;
            hand = hand + 8'd1;
            found = 1'b1;
          end
        end
        fr_used[f] = 1'b1;
        fr_ref[f] = 1'b1;
        fr_owner[f] = rq.process;
        fr_page[f] = rq.address[14:10];
        pg_valid[e] = 1'b1;
        pg_dirty[e] = rq.is_write;
        pg_frame[e] = 8'(f);
        r.frame = 8'(f);
        r.cost_ns = add_cost(r.cost_ns, cost_regs.fault_cost);
        if (rq.is_write) r.cost_ns = add_cost(r.cost_ns, cost_regs.write_fault_cost);
      end
    end
    return r;
  endfunction

  // Results are taken at the rising edge on which done_o is high.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, res_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (res_o !== want) begin
          $display("%0t: result mismatch expected %p actual %p", $realtime, want, res_o);
          errors++;
        end
        if (want.evicted) evictions_seen++;
      end
    end
  end

  // A directed row: the request and, where it is obvious, the result.
  typedef struct {
    req_t req;
    logic fixed;
    res_t res;
  } directed_row_t;

  directed_row_t directed_rows[$];

  task automatic idle_cycles(int unsigned n);
    repeat (n) @(negedge clk_i);
  endtask

  // Short gaps mostly, now and then a long one, and stretches with none.
  // Start drops only when a gap follows; otherwise the next request takes over.
  task automatic random_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return;
    else if (roll < 92) begin
      start <= 1'b0;
      idle_cycles($urandom_range(1, 3));
    end else begin
      start <= 1'b0;
      idle_cycles($urandom_range(10, 60));
    end
  endtask

  // Presents one request and holds it until the block takes it. The
  // expectation is computed at the accepting edge so table order matches.
  // Start stays high afterwards; the block is busy until the result.
  task automatic send_request(req_t rq, logic fixed, res_t fixed_res);
    res_t r;
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = translate(rq);
    if (fixed && r !== fixed_res) begin
      $display("%0t: predictor disagrees with table expected %p actual %p",
               $realtime, fixed_res, r);
      errors++;
    end
    expected_results.push_back(fixed ? fixed_res : r);
    if (!r.hit && !rq.kind) faults_seen++;
    if (rq.kind) terminates_seen++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    idle_cycles(SETTLE_CYCLES);
  endtask

  task automatic write_cost(reg_idx_e idx, logic [23:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_HIT_COST:    cost_regs.hit_cost = value[9:0];
      REG_FAULT_COST:  cost_regs.fault_cost = value;
      REG_WFAULT_COST: cost_regs.write_fault_cost = value;
      REG_WB_COST:     cost_regs.writeback_cost = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic req_t access_req(logic [3:0] proc, logic [14:0] addr, logic wr);
    return '{kind: 1'b0, process: proc, address: addr, is_write: wr};
  endfunction

  function automatic req_t term_req(logic [3:0] proc);
    return '{kind: 1'b1, process: proc, address: 15'($urandom), is_write: 1'($urandom)};
  endfunction

  task automatic add_row(req_t rq, logic fixed, res_t res);
    directed_rows.push_back('{req: rq, fixed: fixed, res: res});
  endtask

  // Random accesses from a few processes, each tending to reuse a small
  // working set so that hits, faults, evictions and dirty victims all occur.
  task automatic random_phase(int unsigned count, int unsigned procs);
    req_t rq;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 4) begin
        rq = term_req(4'($urandom_range(0, procs - 1)));
      end else begin
        rq = access_req(4'($urandom_range(0, procs - 1)),
                        {5'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 31 : 7)),
                         10'($urandom)},
                        1'($urandom));
      end
      send_request(rq, 1'b0, '0);
      random_gap();
    end
  endtask

  initial begin
    res_t r;
    errors = 0;
    results_seen = 0;
    faults_seen = 0;
    evictions_seen = 0;
    terminates_seen = 0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_HIT_COST;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    reset_tables();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. After reset the costs are the reset values, so the
    // first fault and hit results can be typed in directly.
    r = '0; r.frame = 8'd0; r.cost_ns = 30'd14000000;
    add_row(access_req(4'd0, 15'd0, 1'b0), 1'b1, r);
    r = '0; r.hit = 1'b1; r.frame = 8'd0; r.cost_ns = 30'd10;
    add_row(access_req(4'd0, 15'd1023, 1'b1), 1'b1, r);
    r = '0; r.frame = 8'd1; r.cost_ns = 30'd28000000;
    add_row(access_req(4'd15, 15'h7FFF, 1'b1), 1'b1, r);
    r = '0; r.frame = 8'd2; r.cost_ns = 30'd14000000;
    add_row(access_req(4'd15, 15'd0, 1'b0), 1'b1, r);
    // Terminate of a process with no pages frees nothing and costs nothing.
    r = '0;
    add_row(term_req(4'd7), 1'b1, r);
    // Terminate of slot 15: one dirty page, one clean.
    r = '0; r.freed_count = 6'd2; r.cost_ns = 30'd14000000;
    add_row(term_req(4'd15), 1'b1, r);
    // The lowest free frame is reused after a release.
    r = '0; r.frame = 8'd1; r.cost_ns = 30'd14000000;
    add_row(access_req(4'd3, 15'h5555, 1'b0), 1'b1, r);
    add_row(access_req(4'd3, 15'h2AAA, 1'b1), 1'b0, '0);
    add_row(access_req(4'd0, 15'h0400, 1'b0), 1'b0, '0);
    add_row(term_req(4'd0), 1'b0, '0);
    add_row(term_req(4'd3), 1'b0, '0);
    foreach (directed_rows[i]) send_request(directed_rows[i].req, directed_rows[i].fixed,
                                            directed_rows[i].res);
    drain();

    // Fill every frame, then fault further so the hand sweeps and evicts;
    // costs at full scale give the largest sums an item can reach.
    write_cost(REG_HIT_COST, 24'h3FF);
    write_cost(REG_FAULT_COST, 24'hFFFFFF);
    write_cost(REG_WFAULT_COST, 24'hFFFFFF);
    write_cost(REG_WB_COST, 24'hFFFFFF);
    for (int p = 0; p < 9; p++)
      for (int g = 0; g < 32; g++) begin
        send_request(access_req(4'(p), {5'(g), 10'($urandom)}, 1'($urandom)), 1'b0, '0);
        random_gap();
      end
    random_phase(RANDOM_REQUESTS / 6, 16);
    // Terminates of every process release all frames that each still holds.
    for (int p = 0; p < 16; p++) send_request(term_req(4'(p)), 1'b0, '0);
    drain();

    // Zero costs, then a few random settings across the range.
    write_cost(REG_HIT_COST, 24'd0);
    write_cost(REG_FAULT_COST, 24'd0);
    write_cost(REG_WFAULT_COST, 24'd0);
    write_cost(REG_WB_COST, 24'd0);
    random_phase(RANDOM_REQUESTS / 4, 16);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      write_cost(REG_HIT_COST, 24'($urandom));
      write_cost(REG_FAULT_COST, 24'($urandom));
      write_cost(REG_WFAULT_COST, 24'($urandom));
      write_cost(REG_WB_COST, 24'($urandom));
      random_phase(RANDOM_REQUESTS / 5, (ph == 0) ? 4 : 16);
      drain();
    end

    // Every expected result has arrived by now and the sender waited for it.
    $display("Covered %0d results: %0d faults, %0d evictions, %0d terminates.",
             results_seen, faults_seen, evictions_seen, terminates_seen);
    $display("Cost registers went through reset, zero, full-scale and random values.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Ends the run with an error if the test hangs, long after any request's worst case.
  initial begin
    #(64'd8 * 64'd4000000);
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== files.f =====
design/scpr_pkg.sv
design/scpr_cfg_regs.sv
design/scpr_engine.sv
design/second_chance_page_replacer_top.sv
design/scpr_checker.sv
verif/tb.sv
